// ===== hdl/mspv2_frame_receiver_unit_defines.svh =====
// Assertion macros used by the frame receiver parser.
`ifndef MSPV2_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define MSPV2_FRAME_RECEIVER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define MSPV2_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("mspv2 assertion failed");

// next-cycle implication
`define MSPV2_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("mspv2 assertion failed");

`else

`define MSPV2_ASSERT_NOW(label, clk, rst_n, cond, prop)
`define MSPV2_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// ===== hdl/mspv2_pkg.sv =====
// Types, constants and the CRC-8 step for the MSPv2 frame receiver.
`default_nettype none

package mspv2_pkg;

    localparam logic [7:0] CRC_POLY   = 8'hD5;
    localparam logic [7:0] CRC_TOP    = 8'h80;
    localparam logic [7:0] SYNC_X     = 8'h58;
    localparam logic [7:0] MARK_CMD   = 8'h3C;
    localparam logic [7:0] MARK_REPLY = 8'h3E;
    localparam int unsigned HEADER_LEN = 5;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_GOT_X   = 3'd1,
        ST_HEADER  = 3'd2,
        ST_PAYLOAD = 3'd3,
        ST_CHECK   = 3'd4
    } stage_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PAYLOAD = 2'd1,
        EV_GOOD    = 2'd2,
        EV_BAD     = 2'd3
    } event_t;

    typedef struct packed {
        event_t      event_res;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic        is_reply;
        logic [15:0] command_id;
        logic [7:0]  frame_flags;
        logic [15:0] payload_length;
        logic        in_frame;
    } result_t;

    // one byte of CRC-8, MSB first, no reflection
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if ((v & CRC_TOP) != 8'h00)
            begin
                v = (v << 1) ^ CRC_POLY;
            end
            else
            begin
                v = v << 1;
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mspv2_parser.sv =====
// Frame parser: stage machine, header capture, running CRC and result formation.
`default_nettype none
`include "mspv2_frame_receiver_unit_defines.svh"

module mspv2_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire logic [7:0]        rx_byte,
    output mspv2_pkg::result_t     res
);

    mspv2_pkg::stage_t stage_reg, stage_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  crc_reg, crc_next;
    logic        reply_reg, reply_next;
    logic [15:0] cmd_reg, cmd_next;
    logic [7:0]  flags_reg, flags_next;
    logic [15:0] size_reg, size_next;
    logic [7:0]  hdr_reg [4];
    logic        hdr_we;
    logic [15:0] count_inc;
    logic [15:0] size_hdr;

    assign count_inc = count_reg + 16'd1;
    assign size_hdr  = {rx_byte, hdr_reg[3]};

    always_comb
    begin
        stage_next = stage_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        reply_next = reply_reg;
        cmd_next   = cmd_reg;
        flags_next = flags_reg;
        size_next  = size_reg;
        hdr_we     = 1'b0;
        res        = '0;
        res.event_res = mspv2_pkg::EV_NONE;

        case (stage_reg)
            mspv2_pkg::ST_GOT_X:
            begin
                if (rx_byte == mspv2_pkg::MARK_CMD)
                begin
                    reply_next = 1'b0;
                    stage_next = mspv2_pkg::ST_HEADER;
                end
                else if (rx_byte == mspv2_pkg::MARK_REPLY)
                begin
                    reply_next = 1'b1;
                    stage_next = mspv2_pkg::ST_HEADER;
                end
                else
                begin
                    stage_next = mspv2_pkg::ST_IDLE;
                end
            end

            mspv2_pkg::ST_HEADER:
            begin
                crc_next = mspv2_pkg::crc8_step(crc_reg, rx_byte);
                if (count_reg < 16'(mspv2_pkg::HEADER_LEN - 1))
                begin
                    hdr_we     = 1'b1;
                    count_next = count_inc;
                end
                else
                begin
                    flags_next = hdr_reg[0];
                    cmd_next   = {hdr_reg[2], hdr_reg[1]};
                    size_next  = size_hdr;
                    count_next = 16'd0;
                    stage_next = (size_hdr != 16'd0) ? mspv2_pkg::ST_PAYLOAD
                                                     : mspv2_pkg::ST_CHECK;
                end
            end

            mspv2_pkg::ST_PAYLOAD:
            begin
                crc_next           = mspv2_pkg::crc8_step(crc_reg, rx_byte);
                res.event_res      = mspv2_pkg::EV_PAYLOAD;
                res.data_byte      = rx_byte;
                res.byte_index     = count_reg;
                res.is_reply       = reply_reg;
                res.command_id     = cmd_reg;
                res.frame_flags    = flags_reg;
                res.payload_length = size_reg;
                count_next         = count_inc;
                if (count_inc == size_reg)
                begin
                    stage_next = mspv2_pkg::ST_CHECK;
                end
            end

            mspv2_pkg::ST_CHECK:
            begin
                res.event_res      = (crc_reg == rx_byte) ? mspv2_pkg::EV_GOOD
                                                          : mspv2_pkg::EV_BAD;
                res.is_reply       = reply_reg;
                res.command_id     = cmd_reg;
                res.frame_flags    = flags_reg;
                res.payload_length = size_reg;
                stage_next         = mspv2_pkg::ST_IDLE;
            end

            default:
            begin
                count_next = 16'd0;
                crc_next   = 8'h00;
                stage_next = (rx_byte == mspv2_pkg::SYNC_X) ? mspv2_pkg::ST_GOT_X
                                                            : mspv2_pkg::ST_IDLE;
            end
        endcase

        res.in_frame = (stage_next != mspv2_pkg::ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= mspv2_pkg::ST_IDLE;
            count_reg <= 16'd0;
            crc_reg   <= 8'h00;
            reply_reg <= 1'b0;
            cmd_reg   <= 16'd0;
            flags_reg <= 8'h00;
            size_reg  <= 16'd0;
        end
        else if (fire)
        begin
            stage_reg <= stage_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
            reply_reg <= reply_next;
            cmd_reg   <= cmd_next;
            flags_reg <= flags_next;
            size_reg  <= size_next;
        end
    end

    // header bytes are always written before they are read
    always_ff @(posedge clk)
    begin
        if (fire && hdr_we)
        begin
            hdr_reg[count_reg[1:0]] <= rx_byte;
        end
    end

    `MSPV2_ASSERT_NOW(a_payload_size_nonzero, clk, rst_n,
        stage_reg == mspv2_pkg::ST_PAYLOAD, size_reg != 16'd0)
    `MSPV2_ASSERT_NOW(a_header_count_bound, clk, rst_n,
        stage_reg == mspv2_pkg::ST_HEADER, count_reg < 16'(mspv2_pkg::HEADER_LEN))
    `MSPV2_ASSERT_NEXT(a_check_ends_frame, clk, rst_n,
        fire && stage_reg == mspv2_pkg::ST_CHECK, stage_reg == mspv2_pkg::ST_IDLE)
    `MSPV2_ASSERT_NOW(a_payload_index_bound, clk, rst_n,
        stage_reg == mspv2_pkg::ST_PAYLOAD, count_reg < size_reg)

endmodule

`default_nettype wire

// ===== hdl/mspv2_out_reg.sv =====
// Result register with valid/ready toward the consumer.
`default_nettype none

module mspv2_out_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire mspv2_pkg::result_t res_in,
    output logic                    can_take,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mspv2_pkg::result_t      res_out
);

    logic               valid_reg;
    mspv2_pkg::result_t res_reg;

    // a new beat may load in the same cycle the held one drains
    assign can_take  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_take)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_take && load)
        begin
            res_reg <= res_in;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mspv2_frame_receiver_unit.sv =====
// Top level of the MSPv2 native frame receiver.
// Accepts one received byte per beat and returns one result beat per byte, sustaining
// one byte per clock cycle while the output is not stalled. A byte passes an input
// register, then the parser (stage machine and a one-byte CRC-8 update, both
// combinational over registered state) into the result register. Payload bytes stream
// out with their index; the check byte reports a good or bad frame together with the
// decoded header. in_ready follows out_ready within the same cycle when both registers
// are full.
`default_nettype none

module mspv2_frame_receiver_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       event_res,
    output logic [7:0]       data_byte,
    output logic [15:0]      byte_index,
    output logic             is_reply,
    output logic [15:0]      command_id,
    output logic [7:0]       frame_flags,
    output logic [15:0]      payload_length,
    output logic             in_frame
);

    logic               in_valid_reg;
    logic [7:0]         byte_reg;
    logic               can_take;
    logic               fire;
    mspv2_pkg::result_t res_comb;
    mspv2_pkg::result_t res_q;

    assign fire     = in_valid_reg && can_take;
    assign in_ready = !in_valid_reg || can_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= rx_byte;
        end
    end

    mspv2_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .rx_byte (byte_reg),
        .res     (res_comb)
    );

    mspv2_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_valid_reg),
        .res_in    (res_comb),
        .can_take  (can_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (res_q)
    );

    assign event_res      = res_q.event_res;
    assign data_byte      = res_q.data_byte;
    assign byte_index     = res_q.byte_index;
    assign is_reply       = res_q.is_reply;
    assign command_id     = res_q.command_id;
    assign frame_flags    = res_q.frame_flags;
    assign payload_length = res_q.payload_length;
    assign in_frame       = res_q.in_frame;

endmodule

`default_nettype wire
